>>> rtl/pve_pkg.sv
package pve_pkg;

	localparam int AXES     = 3;
	localparam int POS_W    = 32;
	localparam int VEL_W    = 48;
	localparam int FRAC_W   = 20;
	localparam int RECIP_W  = 21;
	localparam int SRC_W    = POS_W + 1;
	localparam int PROD_W   = SRC_W + RECIP_W + 1;
	localparam int DIFF_W   = POS_W + 4;
	localparam int RV_W     = 45;
	localparam int RSUM_W   = RV_W + 1;
	localparam int B_W      = 11;
	localparam int FF_W     = RSUM_W + B_W + 1;
	localparam int COEF_W   = 23;
	localparam int HALF_W   = VEL_W / 2;
	localparam int ACC_W    = 72;
	localparam int ROUND_HALF = 1 << (FRAC_W - 1);

	localparam logic signed [RV_W-1:0]   RV_SCALE = RV_W'(500);
	localparam logic signed [B_W-1:0]    COEF_B0  = B_W'(230);
	localparam logic signed [B_W-1:0]    COEF_B1  = B_W'(691);
	localparam logic signed [COEF_W-1:0] COEF_A1  = COEF_W'(2882326);
	localparam logic signed [COEF_W-1:0] COEF_A2  = COEF_W'(2651010);
	localparam logic signed [COEF_W-1:0] COEF_A3  = COEF_W'(815373);

	typedef enum logic [1:0] {
		UNIT_MM,
		UNIT_CM,
		UNIT_DM,
		UNIT_M
	} unit_t;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [VEL_W-1:0] vel_t;

	typedef struct packed {
		pos_t raw_x;
		pos_t raw_y;
		pos_t raw_z;
	} sample_t;

	typedef struct packed {
		pos_t pos_x;
		pos_t pos_y;
		pos_t pos_z;
		vel_t vel_x;
		vel_t vel_y;
		vel_t vel_z;
	} result_t;

	// reciprocal of the unit divisor, Q1.20
	function automatic logic [RECIP_W-1:0] unit_recip(input unit_t u);
		logic [RECIP_W-1:0] r;
		unique case (u)
			UNIT_MM: r = RECIP_W'(1048576);
			UNIT_CM: r = RECIP_W'(104858);
			UNIT_DM: r = RECIP_W'(10486);
			UNIT_M:  r = RECIP_W'(1049);
		endcase
		return r;
	endfunction

	// 48-bit value times a coefficient, as two half-width partial products
	function automatic logic signed [ACC_W-1:0] mul_coef(
		input logic signed [VEL_W-1:0]  x,
		input logic signed [COEF_W-1:0] c
	);
		logic signed [VEL_W-HALF_W-1:0]        xh;
		logic signed [HALF_W:0]                xl;
		logic signed [VEL_W-HALF_W+COEF_W-1:0] ph;
		logic signed [HALF_W+COEF_W:0]         pl;
		xh = x[VEL_W-1:HALF_W];
		xl = $signed({1'b0, x[HALF_W-1:0]});
		ph = xh * c;
		pl = xl * c;
		return (ACC_W'(ph) <<< HALF_W) + ACC_W'(pl);
	endfunction

endpackage

>>> rtl/position_velocity_estimator_unit.sv
// Position and velocity estimator. Each sample word carries one raw 3-axis
// translation (Q15.16 mm); each result word carries the position remapped to
// (x, -z, y) and scaled to the unit chosen by unit_select, plus the velocity
// from a second-order backward difference smoothed by a third-order low-pass
// (Q31.16, saturated). One result word per sample word, in order. The block
// takes one sample word per clock while the result side does not stall; each
// sample is registered through stages s1 to s5, and s5 drives the result.
// Result-side stalls hold the pipeline; empty stages still fill. The recursive
// filter closes in the last stage: one multiply-accumulate on the previous
// output per sample, with feed-forward terms from a stage earlier and older
// feedback terms precomputed one sample ahead. Reset clears all history and
// selects millimetres; write cfg_wdata only while no word is in flight.
module position_velocity_estimator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  pve_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output pve_pkg::result_t  result
);

	pve_pkg::unit_t unit_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	pve_pkg::sample_t sample_s1;

	pve_pkg::pos_t pos_s2 [pve_pkg::AXES];
	pve_pkg::pos_t pos_s3 [pve_pkg::AXES];
	pve_pkg::pos_t pos_s4 [pve_pkg::AXES];
	pve_pkg::pos_t pos_s5 [pve_pkg::AXES];
	pve_pkg::vel_t vel_s5 [pve_pkg::AXES];

	logic signed [pve_pkg::RV_W-1:0]  rv_s3 [pve_pkg::AXES];
	logic signed [pve_pkg::FF_W-1:0]  ff_s4 [pve_pkg::AXES];

	pve_pkg::pos_t                    ph0_q  [pve_pkg::AXES];
	pve_pkg::pos_t                    ph1_q  [pve_pkg::AXES];
	logic signed [pve_pkg::RV_W-1:0]  rh0_q  [pve_pkg::AXES];
	logic signed [pve_pkg::RV_W-1:0]  rh1_q  [pve_pkg::AXES];
	logic signed [pve_pkg::RV_W-1:0]  rh2_q  [pve_pkg::AXES];
	pve_pkg::vel_t                    fh0_q  [pve_pkg::AXES];
	pve_pkg::vel_t                    fh1_q  [pve_pkg::AXES];
	logic signed [pve_pkg::ACC_W-1:0] fbp_q  [pve_pkg::AXES];

	logic signed [pve_pkg::SRC_W-1:0]  src      [pve_pkg::AXES];
	logic signed [pve_pkg::PROD_W-1:0] prod     [pve_pkg::AXES];
	logic signed [pve_pkg::PROD_W-1:0] prod_rnd [pve_pkg::AXES];
	pve_pkg::pos_t                     pos_next [pve_pkg::AXES];
	logic signed [pve_pkg::RECIP_W:0]  recip;

	logic signed [pve_pkg::DIFF_W-1:0] diff    [pve_pkg::AXES];
	logic signed [pve_pkg::RV_W-1:0]   rv_next [pve_pkg::AXES];

	logic signed [pve_pkg::RSUM_W-1:0] rsum0   [pve_pkg::AXES];
	logic signed [pve_pkg::RSUM_W-1:0] rsum1   [pve_pkg::AXES];
	logic signed [pve_pkg::FF_W-1:0]   ffm0    [pve_pkg::AXES];
	logic signed [pve_pkg::FF_W-1:0]   ffm1    [pve_pkg::AXES];
	logic signed [pve_pkg::FF_W-1:0]   ff_next [pve_pkg::AXES];

	logic signed [pve_pkg::ACC_W-1:0]  acc      [pve_pkg::AXES];
	logic signed [pve_pkg::ACC_W-1:0]  acc_rnd  [pve_pkg::AXES];
	logic signed [pve_pkg::ACC_W-1:0]  fbp_next [pve_pkg::AXES];
	pve_pkg::vel_t                     vel_next [pve_pkg::AXES];
	logic [pve_pkg::ACC_W-pve_pkg::VEL_W:0] upper [pve_pkg::AXES];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= pve_pkg::UNIT_MM;
		end else if (cfg_we) begin
			unit_q <= pve_pkg::unit_t'(cfg_wdata);
		end
	end

	// handshake chain
	assign rdy_s5       = !valid_s5 || result_ready;
	assign rdy_s4       = !valid_s4 || rdy_s5;
	assign rdy_s3       = !valid_s3 || rdy_s4;
	assign rdy_s2       = !valid_s2 || rdy_s3;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign sample_ready = rdy_s1;
	assign result_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= sample_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// remap and unit scaling
	always_comb begin
		recip  = $signed({1'b0, pve_pkg::unit_recip(unit_q)});
		src[0] = pve_pkg::SRC_W'(sample_s1.raw_x);
		src[1] = -pve_pkg::SRC_W'(sample_s1.raw_z);
		src[2] = pve_pkg::SRC_W'(sample_s1.raw_y);
		for (int a = 0; a < pve_pkg::AXES; a++) begin
			prod[a]     = src[a] * recip;
			prod_rnd[a] = (prod[a] + pve_pkg::PROD_W'(pve_pkg::ROUND_HALF)) >>> pve_pkg::FRAC_W;
			pos_next[a] = prod_rnd[a][pve_pkg::POS_W-1:0];
		end
	end

	// backward difference
	always_comb begin
		for (int a = 0; a < pve_pkg::AXES; a++) begin
			diff[a] = (pve_pkg::DIFF_W'(pos_s2[a]) <<< 1) + pve_pkg::DIFF_W'(pos_s2[a])
				- (pve_pkg::DIFF_W'(ph0_q[a]) <<< 2) + pve_pkg::DIFF_W'(ph1_q[a]);
			rv_next[a] = pve_pkg::RV_W'(diff[a]) * pve_pkg::RV_SCALE;
		end
	end

	// feed-forward taps
	always_comb begin
		for (int a = 0; a < pve_pkg::AXES; a++) begin
			rsum0[a]   = pve_pkg::RSUM_W'(rv_s3[a]) + pve_pkg::RSUM_W'(rh2_q[a]);
			rsum1[a]   = pve_pkg::RSUM_W'(rh0_q[a]) + pve_pkg::RSUM_W'(rh1_q[a]);
			ffm0[a]    = rsum0[a] * pve_pkg::COEF_B0;
			ffm1[a]    = rsum1[a] * pve_pkg::COEF_B1;
			ff_next[a] = ffm0[a] + ffm1[a];
		end
	end

	// feedback, rounding and saturation
	always_comb begin
		for (int a = 0; a < pve_pkg::AXES; a++) begin
			acc[a] = pve_pkg::ACC_W'(ff_s4[a]) + fbp_q[a]
				+ pve_pkg::mul_coef(fh0_q[a], pve_pkg::COEF_A1);
			acc_rnd[a] = (acc[a] + pve_pkg::ACC_W'(pve_pkg::ROUND_HALF)) >>> pve_pkg::FRAC_W;
			upper[a]   = acc_rnd[a][pve_pkg::ACC_W-1:pve_pkg::VEL_W-1];
			if (&upper[a] || ~|upper[a]) begin
				vel_next[a] = acc_rnd[a][pve_pkg::VEL_W-1:0];
			end else if (acc_rnd[a][pve_pkg::ACC_W-1]) begin
				vel_next[a] = {1'b1, {(pve_pkg::VEL_W-1){1'b0}}};
			end else begin
				vel_next[a] = {1'b0, {(pve_pkg::VEL_W-1){1'b1}}};
			end
			fbp_next[a] = pve_pkg::mul_coef(fh1_q[a], pve_pkg::COEF_A3)
				- pve_pkg::mul_coef(fh0_q[a], pve_pkg::COEF_A2);
		end
	end

	// pipeline data
	always_ff @(posedge clk) begin
		if (rdy_s1 && sample_valid) begin
			sample_s1 <= sample;
		end
		if (rdy_s2 && valid_s1) begin
			pos_s2 <= pos_next;
		end
		if (rdy_s3 && valid_s2) begin
			pos_s3 <= pos_s2;
			rv_s3  <= rv_next;
		end
		if (rdy_s4 && valid_s3) begin
			pos_s4 <= pos_s3;
			ff_s4  <= ff_next;
		end
		if (rdy_s5 && valid_s4) begin
			pos_s5 <= pos_s4;
			vel_s5 <= vel_next;
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < pve_pkg::AXES; a++) begin
				ph0_q[a] <= '0;
				ph1_q[a] <= '0;
				rh0_q[a] <= '0;
				rh1_q[a] <= '0;
				rh2_q[a] <= '0;
				fh0_q[a] <= '0;
				fh1_q[a] <= '0;
				fbp_q[a] <= '0;
			end
		end else begin
			if (rdy_s3 && valid_s2) begin
				ph1_q <= ph0_q;
				ph0_q <= pos_s2;
			end
			if (rdy_s4 && valid_s3) begin
				rh2_q <= rh1_q;
				rh1_q <= rh0_q;
				rh0_q <= rv_s3;
			end
			if (rdy_s5 && valid_s4) begin
				fh1_q <= fh0_q;
				fh0_q <= vel_next;
				fbp_q <= fbp_next;
			end
		end
	end

	always_comb begin
		result.pos_x = pos_s5[0];
		result.pos_y = pos_s5[1];
		result.pos_z = pos_s5[2];
		result.vel_x = vel_s5[0];
		result.vel_y = vel_s5[1];
		result.vel_z = vel_s5[2];
	end

endmodule
